[rtl/sia_pkg.sv]
`timescale 1ns / 1ps
// Shared constants for the signed integer ALU: operation codes, status codes,
// field and bus widths. No dependencies.
package sia_pkg;

    localparam int WORD_BITS_DEF = 128;
    localparam int FULL_W        = 128;
    localparam int HALF_W        = 64;
    localparam int MODE_W        = 5;
    localparam int SHAMT_W       = 7;
    localparam int ST_W          = 2;
    localparam int MUL_DIGIT     = 8;
    localparam int S_TDATA_W     = 272;
    localparam int M_TDATA_W     = 136;

    localparam logic [MODE_W-1:0] MODE_ADD = 5'd0;
    localparam logic [MODE_W-1:0] MODE_SUB = 5'd1;
    localparam logic [MODE_W-1:0] MODE_MUL = 5'd2;
    localparam logic [MODE_W-1:0] MODE_DIV = 5'd3;
    localparam logic [MODE_W-1:0] MODE_AND = 5'd4;
    localparam logic [MODE_W-1:0] MODE_OR  = 5'd5;
    localparam logic [MODE_W-1:0] MODE_XOR = 5'd6;
    localparam logic [MODE_W-1:0] MODE_NOT = 5'd7;
    localparam logic [MODE_W-1:0] MODE_SHL = 5'd8;
    localparam logic [MODE_W-1:0] MODE_SAR = 5'd9;
    localparam logic [MODE_W-1:0] MODE_ROL = 5'd10;
    localparam logic [MODE_W-1:0] MODE_ROR = 5'd11;
    localparam logic [MODE_W-1:0] MODE_LT  = 5'd12;
    localparam logic [MODE_W-1:0] MODE_GT  = 5'd13;
    localparam logic [MODE_W-1:0] MODE_EQ  = 5'd14;
    localparam logic [MODE_W-1:0] MODE_GE  = 5'd15;
    localparam logic [MODE_W-1:0] MODE_LE  = 5'd16;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_OVF  = 2'd1;
    localparam logic [ST_W-1:0] ST_DIV0 = 2'd2;

endpackage

[rtl/signed_int128_alu_top.sv]
`timescale 1ns / 1ps
// Signed integer ALU, top level. Uses sia_pkg, sia_front, sia_mul, sia_div
// and sia_delay.
//
// One beat on the s_ channel carries an operation, two operands and a shift
// amount; exactly one beat leaves on the m_ channel with the result and its
// status, in the order the operations arrived. Every operation, cheap or not,
// takes the same path: an input register, a decode stage, WORD_BITS stages of
// the restoring divider (with the multiplier and the side data running beside
// it) and an output register. A new beat is accepted in every cycle in which
// the pipeline is not stalled; throughput is then one operation per cycle,
// set by the one-bit-per-stage divider pipeline.
// The whole pipeline advances together: when m_tvalid is high and m_tready is
// low, every stage holds and s_tready drops, so nothing is lost or repeated.
// A synchronous low aresetn clears all valid bits; results in flight are
// dropped and the block is ready as soon as aresetn is released.
// Operands are read as signed WORD_BITS-bit values; results are sign-extended
// to 128 bits. On overflow or division by zero the result is zero.
module signed_int128_alu_top #(
    parameter int WORD_BITS = sia_pkg::WORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // mode[4:0], operand_a_hi[68:5], operand_a_lo[132:69], operand_b_hi[196:133],
    // operand_b_lo[260:197], shift_amount[267:261], zero fill up to bit 271
    input  logic [sia_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // result_hi[63:0], result_lo[127:64], status[129:128], zero fill to bit 135
    output logic [sia_pkg::M_TDATA_W-1:0] m_tdata
);
    import sia_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int NM = (W + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int SW = MODE_W + W + ST_W + 2;

    logic                en;
    logic [FULL_W-1:0]   a_full, b_full;

    logic                va_reg;
    logic [MODE_W-1:0]   mode_a_reg;
    logic [W-1:0]        a_a_reg, b_a_reg;
    logic [SHAMT_W-1:0]  k_a_reg;

    logic                vb;
    logic [MODE_W-1:0]   mode_b;
    logic [W-1:0]        res_b, ma_b, mb_b;
    logic [ST_W-1:0]     st_b;
    logic                ng_b, bzero_b;

    logic [2*W-1:0]      prod_m;
    logic [W-1:0]        q_d;
    logic                v1, vf;
    logic [SW-1:0]       side1;
    logic [SW+2*W-1:0]   side2;

    logic [MODE_W-1:0]   mode_f;
    logic [W-1:0]        res_f, r_sel;
    logic [ST_W-1:0]     st_f, st_sel;
    logic                ng_f, bzero_f;
    logic [2*W-1:0]      prod_f;

    logic                m_valid_reg;
    logic [FULL_W-1:0]   m_res_reg;
    logic [ST_W-1:0]     m_st_reg;

    assign en       = !m_valid_reg || m_tready;
    // No beat is taken while reset is held, since it would be dropped.
    assign s_tready = en && aresetn;

    assign a_full = {s_tdata[68:5], s_tdata[132:69]};
    assign b_full = {s_tdata[196:133], s_tdata[260:197]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode_a_reg <= s_tdata[4:0];
            a_a_reg    <= a_full[W-1:0];
            b_a_reg    <= b_full[W-1:0];
            k_a_reg    <= s_tdata[267:261];
        end
    end

    sia_front #(.W(W)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (va_reg),
        .in_mode   (mode_a_reg),
        .in_a      (a_a_reg),
        .in_b      (b_a_reg),
        .in_shamt  (k_a_reg),
        .out_valid (vb),
        .out_mode  (mode_b),
        .out_res   (res_b),
        .out_st    (st_b),
        .out_ng    (ng_b),
        .out_bzero (bzero_b),
        .out_ma    (ma_b),
        .out_mb    (mb_b)
    );

    sia_mul #(.W(W)) u_mul (
        .aclk     (aclk),
        .en       (en),
        .in_ma    (ma_b),
        .in_mb    (mb_b),
        .out_prod (prod_m)
    );

    sia_div #(.W(W)) u_div (
        .aclk  (aclk),
        .en    (en),
        .in_ma (ma_b),
        .in_mb (mb_b),
        .out_q (q_d)
    );

    // Side data runs beside the multiplier, then with the product beside the
    // remaining divider stages.
    sia_delay #(.DW(SW), .DEPTH(NM)) u_side_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vb),
        .in_data   ({mode_b, res_b, st_b, ng_b, bzero_b}),
        .out_valid (v1),
        .out_data  (side1)
    );

    sia_delay #(.DW(SW + 2*W), .DEPTH(W - NM)) u_side_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v1),
        .in_data   ({side1, prod_m}),
        .out_valid (vf),
        .out_data  (side2)
    );

    assign {mode_f, res_f, st_f, ng_f, bzero_f, prod_f} = side2;

    always_comb begin
        r_sel  = res_f;
        st_sel = st_f;
        case (mode_f)
            MODE_MUL: begin
                r_sel  = ng_f ? -prod_f[W-1:0] : prod_f[W-1:0];
                st_sel = ST_OK;
                if (prod_f[2*W-1:W-1] != '0 &&
                    !(ng_f && prod_f == ((2*W)'(1) << (W-1)))) begin
                    st_sel = ST_OVF;
                end
            end
            MODE_DIV: begin
                r_sel  = ng_f ? -q_d : q_d;
                st_sel = ST_OK;
                if (bzero_f) begin
                    st_sel = ST_DIV0;
                end else if (q_d[W-1] && !(ng_f && q_d[W-2:0] == '0)) begin
                    st_sel = ST_OVF;
                end
            end
            default: begin
                r_sel  = res_f;
                st_sel = st_f;
            end
        endcase
        if (st_sel != ST_OK) r_sel = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vf;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_res_reg <= FULL_W'(signed'(r_sel));
            m_st_reg  <= st_sel;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_st_reg, m_res_reg[HALF_W-1:0], m_res_reg[FULL_W-1:HALF_W]};
endmodule

[rtl/sia_delay.sv]
`timescale 1ns / 1ps
// Stall-aware delay line that carries a valid bit and a payload.
// Depends on nothing.
module sia_delay #(
    parameter int DW    = 8,
    parameter int DEPTH = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_data,
    output logic          out_valid,
    output logic [DW-1:0] out_data
);
    logic          valid_reg [DEPTH];
    logic [DW-1:0] data_reg  [DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) valid_reg[i] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < DEPTH; i++) valid_reg[i] <= valid_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg[0] <= in_data;
            for (int i = 1; i < DEPTH; i++) data_reg[i] <= data_reg[i-1];
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign out_data  = data_reg[DEPTH-1];
endmodule

[rtl/sia_front.sv]
`timescale 1ns / 1ps
// Decode stage: add/sub, logic, shifts, rotates, compares and operand
// magnitudes for the multiplier and divider. Uses sia_pkg.
module sia_front #(
    parameter int W = sia_pkg::WORD_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [sia_pkg::MODE_W-1:0]  in_mode,
    input  logic [W-1:0]                in_a,
    input  logic [W-1:0]                in_b,
    input  logic [sia_pkg::SHAMT_W-1:0] in_shamt,
    output logic                        out_valid,
    output logic [sia_pkg::MODE_W-1:0]  out_mode,
    output logic [W-1:0]                out_res,
    output logic [sia_pkg::ST_W-1:0]    out_st,
    output logic                        out_ng,
    output logic                        out_bzero,
    output logic [W-1:0]                out_ma,
    output logic [W-1:0]                out_mb
);
    import sia_pkg::*;

    localparam logic [SHAMT_W:0] W_K = (SHAMT_W+1)'(W);

    logic                valid_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [W-1:0]        res_reg, res_next, ma_reg, mb_reg;
    logic [ST_W-1:0]     st_reg, st_next;
    logic                ng_reg, bzero_reg;
    logic                sa, sb, k_big, lt, gt, eq;
    logic [W-1:0]        sum, diff, shl, sar;
    logic [W-1:0]        rl [SHAMT_W+1];
    logic [W-1:0]        rr [SHAMT_W+1];

    assign sa    = in_a[W-1];
    assign sb    = in_b[W-1];
    assign sum   = in_a + in_b;
    assign diff  = in_a - in_b;
    assign k_big = {1'b0, in_shamt} >= W_K;
    assign shl   = k_big ? '0 : (in_a << in_shamt);
    assign sar   = k_big ? {W{sa}} : W'($signed(in_a) >>> in_shamt);
    assign lt    = $signed(in_a) < $signed(in_b);
    assign gt    = $signed(in_b) < $signed(in_a);
    assign eq    = in_a == in_b;

    // Each amount bit rotates by its weight taken modulo the word width.
    assign rl[0] = in_a;
    assign rr[0] = in_a;
    for (genvar j = 0; j < SHAMT_W; j++) begin : g_rot
        localparam int C = (1 << j) % W;
        assign rl[j+1] = in_shamt[j] ? ((rl[j] << C) | (rl[j] >> (W - C))) : rl[j];
        assign rr[j+1] = in_shamt[j] ? ((rr[j] >> C) | (rr[j] << (W - C))) : rr[j];
    end

    always_comb begin
        res_next = '0;
        st_next  = ST_OK;
        case (in_mode)
            MODE_ADD: begin
                res_next = sum;
                if (sa == sb && sum[W-1] != sa) st_next = ST_OVF;
            end
            MODE_SUB: begin
                res_next = diff;
                if (sa != sb && diff[W-1] != sa) st_next = ST_OVF;
            end
            MODE_AND: res_next = in_a & in_b;
            MODE_OR:  res_next = in_a | in_b;
            MODE_XOR: res_next = in_a ^ in_b;
            MODE_NOT: res_next = ~in_a;
            MODE_SHL: res_next = shl;
            MODE_SAR: res_next = sar;
            MODE_ROL: res_next = rl[SHAMT_W];
            MODE_ROR: res_next = rr[SHAMT_W];
            MODE_LT:  res_next = W'(lt);
            MODE_GT:  res_next = W'(gt);
            MODE_EQ:  res_next = W'(eq);
            MODE_GE:  res_next = W'(!lt);
            MODE_LE:  res_next = W'(!gt);
            default:  res_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode_reg  <= in_mode;
            res_reg   <= res_next;
            st_reg    <= st_next;
            ng_reg    <= sa ^ sb;
            bzero_reg <= in_b == '0;
            ma_reg    <= sa ? -in_a : in_a;
            mb_reg    <= sb ? -in_b : in_b;
        end
    end

    assign out_valid = valid_reg;
    assign out_mode  = mode_reg;
    assign out_res   = res_reg;
    assign out_st    = st_reg;
    assign out_ng    = ng_reg;
    assign out_bzero = bzero_reg;
    assign out_ma    = ma_reg;
    assign out_mb    = mb_reg;
endmodule

[rtl/sia_mul.sv]
`timescale 1ns / 1ps
// Pipelined unsigned multiplier: one 8-bit digit of the multiplier per stage,
// accumulating a double-width product. Uses sia_pkg.
module sia_mul #(
    parameter int W = sia_pkg::WORD_BITS_DEF
) (
    input  logic           aclk,
    input  logic           en,
    input  logic [W-1:0]   in_ma,
    input  logic [W-1:0]   in_mb,
    output logic [2*W-1:0] out_prod
);
    import sia_pkg::*;

    localparam int NM = (W + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int PW = NM * MUL_DIGIT;

    logic [2*W-1:0] acc_reg [NM];
    logic [W-1:0]   a_reg   [NM];
    logic [PW-1:0]  b_reg   [NM];

    for (genvar i = 0; i < NM; i++) begin : g_stage
        logic [2*W-1:0]         acc_in;
        logic [W-1:0]           a_in;
        logic [PW-1:0]          b_in;
        logic [W+MUL_DIGIT-1:0] pp;

        if (i == 0) begin : g_first
            assign acc_in = '0;
            assign a_in   = in_ma;
            assign b_in   = PW'(in_mb);
        end else begin : g_next
            assign acc_in = acc_reg[i-1];
            assign a_in   = a_reg[i-1];
            assign b_in   = b_reg[i-1];
        end

        assign pp = a_in * b_in[i*MUL_DIGIT +: MUL_DIGIT];

        always_ff @(posedge aclk) begin
            if (en) begin
                acc_reg[i] <= acc_in + ((2*W)'(pp) << (i * MUL_DIGIT));
                a_reg[i]   <= a_in;
                b_reg[i]   <= b_in;
            end
        end
    end

    assign out_prod = acc_reg[NM-1];
endmodule

[rtl/sia_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider of unsigned magnitudes: one quotient bit per
// stage, W stages. Uses sia_pkg.
module sia_div #(
    parameter int W = sia_pkg::WORD_BITS_DEF
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] in_ma,
    input  logic [W-1:0] in_mb,
    output logic [W-1:0] out_q
);
    import sia_pkg::*;

    logic [W-1:0] rem_reg [W];
    logic [W-1:0] x_reg   [W];  // dividend bits shift out the top, quotient in
    logic [W-1:0] d_reg   [W];

    for (genvar i = 0; i < W; i++) begin : g_stage
        logic [W-1:0] rem_in, x_in, d_in, trial;
        logic         ge;

        if (i == 0) begin : g_first
            assign rem_in = '0;
            assign x_in   = in_ma;
            assign d_in   = in_mb;
        end else begin : g_next
            assign rem_in = rem_reg[i-1];
            assign x_in   = x_reg[i-1];
            assign d_in   = d_reg[i-1];
        end

        // For a nonzero divisor the remainder stays below it, so its top bit is clear.
        assign trial = {rem_in[W-2:0], x_in[W-1]};
        assign ge    = trial >= d_in;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= ge ? (trial - d_in) : trial;
                x_reg[i]   <= {x_in[W-2:0], ge};
                d_reg[i]   <= d_in;
            end
        end
    end

    assign out_q = x_reg[W-1];
endmodule

[tb/signed_int128_alu_top_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for signed_int128_alu_top: directed and random
// operations against a built-in predictor, with random idling and back pressure.
// Depends on sia_pkg and the signed_int128_alu_top RTL.
module signed_int128_alu_top_test;
    import sia_pkg::*;

    localparam int PIPE_LAT   = 131;
    localparam int STALL_MAX  = 5000;
    localparam int LONG_HOLD  = 400;

    // Highest code the mode field can carry; everything above MODE_LE is unused.
    localparam logic [MODE_W-1:0] MODE_TOP = '1;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [HALF_W-1:0]  a_hi;
        logic [HALF_W-1:0]  a_lo;
        logic [HALF_W-1:0]  b_hi;
        logic [HALF_W-1:0]  b_lo;
        logic [SHAMT_W-1:0] shamt;
    } alu_op_t;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [HALF_W-1:0] r_lo;
        logic [HALF_W-1:0] r_hi;
    } alu_res_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    alu_res_t pending_results[$];
    int       error_count;
    int       quiet_cycles;
    bit       idle_enable;
    bit       hold_request;
    int       hold_left;
    int       ready_gap;

    signed_int128_alu_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [127:0] rotate_left(logic [127:0] x, int unsigned k);
        if (k == 0) begin
            return x;
        end
        return (x << k) | (x >> (128 - k));
    endfunction

    function automatic alu_res_t compute_alu(alu_op_t op);
        logic [127:0]        a;
        logic [127:0]        b;
        logic [127:0]        r;
        logic [127:0]        ma;
        logic [127:0]        mb;
        logic [127:0]        q;
        logic signed [255:0] prod;
        logic                ng;
        logic [ST_W-1:0]     st;
        alu_res_t            res;
        a  = {op.a_hi, op.a_lo};
        b  = {op.b_hi, op.b_lo};
        r  = '0;
        st = ST_OK;
        case (op.mode)
            MODE_ADD: begin
                r = a + b;
                if (a[127] == b[127] && r[127] != a[127]) st = ST_OVF;
            end
            MODE_SUB: begin
                r = a - b;
                if (a[127] != b[127] && r[127] != a[127]) st = ST_OVF;
            end
            MODE_MUL: begin
                prod = $signed({{128{a[127]}}, a}) * $signed({{128{b[127]}}, b});
                r = prod[127:0];
                if (prod[255:127] != '0 && prod[255:127] != '1) st = ST_OVF;
            end
            MODE_DIV: begin
                if (b == '0) begin
                    st = ST_DIV0;
                end else begin
                    ng = a[127] ^ b[127];
                    ma = a[127] ? -a : a;
                    mb = b[127] ? -b : b;
                    q  = ma / mb;
                    // Only a negative quotient may reach the magnitude of the minimum.
                    if (q[127] && !(ng && q == {1'b1, 127'b0})) st = ST_OVF;
                    r = ng ? -q : q;
                end
            end
            MODE_AND: r = a & b;
            MODE_OR:  r = a | b;
            MODE_XOR: r = a ^ b;
            MODE_NOT: r = ~a;
            MODE_SHL: r = a << op.shamt;
            MODE_SAR: r = $signed(a) >>> op.shamt;
            MODE_ROL: r = rotate_left(a, op.shamt);
            MODE_ROR: r = rotate_left(a, (128 - op.shamt) % 128);
            MODE_LT:  r = {127'b0, $signed(a) <  $signed(b)};
            MODE_GT:  r = {127'b0, $signed(a) >  $signed(b)};
            MODE_EQ:  r = {127'b0, a == b};
            MODE_GE:  r = {127'b0, $signed(a) >= $signed(b)};
            MODE_LE:  r = {127'b0, $signed(a) <= $signed(b)};
            default:  r = '0;
        endcase
        if (st != ST_OK) r = '0;
        res.status = st;
        res.r_hi   = r[127:64];
        res.r_lo   = r[63:0];
        return res;
    endfunction

    // Offers one beat from the falling edge on and waits for its acceptance.
    task automatic send_op(alu_op_t op);
        int gap;
        s_tdata  = {4'b0, op.shamt, op.b_lo, op.b_hi, op.a_lo, op.a_hi, op.mode};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_results.insert(pending_results.size(), compute_alu(op));
        @(negedge aclk);
        if (idle_enable && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge aclk);
        end
    endtask

    function automatic logic [127:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 128'd1;
            2: return '1;
            3: return {1'b1, 127'b0};
            4: return {1'b0, {127{1'b1}}};
            5: return {{96{1'b0}}, 32'($urandom)};
            6: return {{96{1'b1}}, 32'($urandom)};
            7: return {{64{1'b0}}, $urandom, $urandom};
            default: return {$urandom, $urandom, $urandom, $urandom};
        endcase
    endfunction

    function automatic alu_op_t random_op(int unsigned mode_hi);
        alu_op_t      op;
        logic [127:0] a;
        logic [127:0] b;
        a = pick_operand();
        b = pick_operand();
        op.mode  = MODE_W'($urandom_range(0, mode_hi));
        op.a_hi  = a[127:64];
        op.a_lo  = a[63:0];
        op.b_hi  = b[127:64];
        op.b_lo  = b[63:0];
        op.shamt = SHAMT_W'($urandom_range(0, 127));
        if ($urandom_range(0, 3) == 0) op.b_lo = op.a_lo;
        if ($urandom_range(0, 3) == 0) op.b_hi = op.a_hi;
        return op;
    endfunction

    function automatic alu_op_t make_op(logic [MODE_W-1:0] mode, logic [127:0] a,
                                        logic [127:0] b, int unsigned k);
        alu_op_t op;
        op.mode  = mode;
        op.a_hi  = a[127:64];
        op.a_lo  = a[63:0];
        op.b_hi  = b[127:64];
        op.b_lo  = b[63:0];
        op.shamt = SHAMT_W'(k);
        return op;
    endfunction

    task automatic test_directed();
        logic [127:0] min_v;
        logic [127:0] max_v;
        min_v = {1'b1, 127'b0};
        max_v = {1'b0, {127{1'b1}}};
        send_op(make_op(MODE_ADD, max_v, 128'd1, 0));
        send_op(make_op(MODE_ADD, min_v, min_v, 0));
        send_op(make_op(MODE_SUB, min_v, 128'd1, 0));
        send_op(make_op(MODE_SUB, '0, min_v, 0));
        send_op(make_op(MODE_MUL, min_v, '1, 0));
        send_op(make_op(MODE_MUL, {64'b0, 64'h8000_0000_0000_0000}, {64'b1, 64'h0}, 0));
        send_op(make_op(MODE_MUL, max_v, max_v, 0));
        send_op(make_op(MODE_DIV, min_v, '1, 0));
        send_op(make_op(MODE_DIV, 128'd7, '0, 0));
        send_op(make_op(MODE_DIV, -128'sd7, 128'd2, 0));
        send_op(make_op(MODE_AND, '1, max_v, 0));
        send_op(make_op(MODE_OR, min_v, 128'd5, 0));
        send_op(make_op(MODE_XOR, '1, max_v, 0));
        send_op(make_op(MODE_NOT, '0, '0, 0));
        send_op(make_op(MODE_SHL, '1, '0, 127));
        send_op(make_op(MODE_SAR, min_v, '0, 127));
        send_op(make_op(MODE_ROL, min_v | 128'd1, '0, 1));
        send_op(make_op(MODE_ROR, 128'd3, '0, 0));
        send_op(make_op(MODE_ROR, 128'd3, '0, 127));
        send_op(make_op(MODE_LT, min_v, max_v, 0));
        send_op(make_op(MODE_GT, '1, '0, 0));
        send_op(make_op(MODE_EQ, max_v, max_v, 0));
        send_op(make_op(MODE_GE, min_v, min_v, 0));
        send_op(make_op(MODE_LE, max_v, min_v, 0));
        send_op(make_op(MODE_TOP, '1, '1, 127));
    endtask

    task automatic test_random_ops(int count);
        repeat (count) begin
            // Codes above the last operation show up now and then.
            send_op(random_op($urandom_range(0, 15) == 0 ? MODE_TOP : MODE_LE));
        end
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        repeat (300) send_op(random_op(MODE_LE));
    endtask

    task automatic test_no_idle_tail();
        idle_enable = 1'b0;
        repeat (200) send_op(random_op(MODE_LE));
    endtask

    // Receiver side: random ready gaps and one long hold-off on request.
    always @(negedge aclk) begin
        if (hold_request && hold_left == 0) begin
            hold_request <= 1'b0;
            hold_left    <= LONG_HOLD;
            m_tready     <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= (hold_left == 1);
        end else if (ready_gap > 0) begin
            ready_gap <= ready_gap - 1;
            m_tready  <= (ready_gap == 1);
        end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            ready_gap <= $urandom_range(1, 4);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        alu_res_t got;
        alu_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = alu_res_t'(m_tdata[129:0]);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat %h", $realtime, got);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.r_hi !== want.r_hi) begin
                    $display("%0t: result_hi expected %h actual %h",
                             $realtime, want.r_hi, got.r_hi);
                    error_count++;
                end
                if (got.r_lo !== want.r_lo) begin
                    $display("%0t: result_lo expected %h actual %h",
                             $realtime, want.r_lo, got.r_lo);
                    error_count++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $realtime, want.status, got.status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_MAX) begin
            $display("signed_int128_alu_top_test NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        error_count  = 0;
        quiet_cycles = 0;
        idle_enable  = 1'b1;
        hold_request = 1'b0;
        hold_left    = 0;
        ready_gap    = 0;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_random_ops(800);
        test_backpressure();
        test_random_ops(200);
        test_no_idle_tail();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 10) @(posedge aclk);
        if (error_count == 0) begin
            $display("signed_int128_alu_top_test OK");
        end else begin
            $display("signed_int128_alu_top_test NOT OK");
        end
        $finish;
    end
endmodule
